// ===== sv/sncs_pkg.sv =====
package sncs_pkg;

  localparam int RowAddrBits = 24;
  localparam int TickBits    = 16;
  localparam int TickCmpW    = (TickBits > 16) ? TickBits : 16;
  localparam int MaxRes      = 7;
  localparam int CntW        = $clog2(MaxRes + 1);

  localparam logic [8:0]  PpbReset  = 9'd64;
  localparam logic [12:0] PtotReset = 13'd2176;
  localparam logic [11:0] PdsReset  = 12'd2048;
  localparam logic [15:0] ToReset   = 16'd100;

  localparam logic [1:0] CFG_PAGES_PER_BLOCK = 2'd0;
  localparam logic [1:0] CFG_PAGE_TOTAL      = 2'd1;
  localparam logic [1:0] CFG_PAGE_DATA_SIZE  = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT_TICKS   = 2'd3;

  localparam logic [2:0] OP_ERASE   = 3'd0;
  localparam logic [2:0] OP_READ    = 3'd1;
  localparam logic [2:0] OP_WRITE   = 3'd2;
  localparam logic [2:0] OP_WR_BYTE = 3'd3;
  localparam logic [2:0] OP_REPLY   = 3'd4;
  localparam logic [2:0] OP_TICK    = 3'd5;

  localparam logic [1:0] KIND_FLASH = 2'd0;
  localparam logic [1:0] KIND_HOST  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ERASE_FAIL = 3'd1;
  localparam logic [2:0] ST_PROG_FAIL  = 3'd2;
  localparam logic [2:0] ST_BAD_BLOCK  = 3'd3;
  localparam logic [2:0] ST_TIMEOUT    = 3'd4;

  localparam logic [7:0] CMD_BLOCK_ERASE  = 8'hD8;
  localparam logic [7:0] CMD_FEATURE_RD   = 8'h0F;
  localparam logic [7:0] CMD_PROG_EXEC    = 8'h10;
  localparam logic [7:0] CMD_PROG_LOAD    = 8'h02;
  localparam logic [7:0] CMD_CACHE_RD     = 8'h03;
  localparam logic [7:0] CMD_PAGE_READ    = 8'h13;
  localparam logic [7:0] CMD_WREN         = 8'h06;
  localparam logic [7:0] CMD_WRITE_DIS    = 8'h04;
  localparam logic [7:0] REG_STATUS_ADDR  = 8'hC0;

  localparam int BitBusy      = 0;
  localparam int BitProgFail  = 3;
  localparam int BitEraseFail = 2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ERASE_POLL,
    PH_READ_POLL,
    PH_READ_DATA,
    PH_LOAD,
    PH_LOAD_POLL,
    PH_EXEC_POLL
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        frame_start;
    logic        frame_end;
    logic [12:0] reply_count;
    logic [2:0]  status_code;
    logic        last;
  } res_t;

  typedef struct packed {
    logic            load;
    logic [CntW-1:0] n;
  } load_t;

endpackage

// ===== sv/sncs_core.sv =====
module sncs_core (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  input  logic [55:0]                                in_tdata,
  input  logic [2:0]                                 in_tuser,
  input  logic                                       cfg_we,
  input  logic [1:0]                                 cfg_index,
  input  logic [15:0]                                cfg_wdata,
  input  logic                                       load_ok,
  output sncs_pkg::load_t                            ld,
  output sncs_pkg::res_t [sncs_pkg::MaxRes-1:0]      list
);
  import sncs_pkg::*;

  logic        vld_r;
  logic [2:0]  op_r;
  logic [15:0] blk_r;
  logic [7:0]  pg_r;
  logic [11:0] col_r;
  logic [11:0] len_r;
  logic [7:0]  db_r;

  logic [8:0]  ppb_r;
  logic [12:0] ptot_r;
  logic [11:0] pds_r;
  logic [15:0] to_r;

  phase_t                 phase_r, phase_nxt;
  logic [RowAddrBits-1:0] row_r, row_nxt;
  logic [12:0]            bc_r, bc_nxt;
  logic [TickBits-1:0]    ticks_r, ticks_nxt;
  logic                   piz_r, piz_nxt;
  logic                   mwz_r, mwz_nxt;
  logic [7:0]             ls_r, ls_nxt;

  logic [7:0]             pg_sel;
  logic [24:0]            prod;
  logic [25:0]            row_sum;
  logic [RowAddrBits-1:0] row_new;
  logic [23:0]            rowb;
  logic [23:0]            row_cur;
  logic [12:0]            bc_dec;
  logic [12:0]            bc_inc;
  logic                   polling;
  logic                   tick_over;
  logic [CntW-1:0]        n;
  res_t [MaxRes-1:0]      res;
  logic                   consume;
  logic                   accept;

  function automatic res_t mk(input logic [1:0] k, input logic [7:0] b, input logic fs,
                              input logic fe, input logic [12:0] rc, input logic [2:0] st);
    res_t r;
    r.kind        = k;
    r.data        = b;
    r.frame_start = fs;
    r.frame_end   = fe;
    r.reply_count = rc;
    r.status_code = st;
    r.last        = 1'b0;
    return r;
  endfunction

  assign pg_sel    = (op_r == OP_ERASE) ? 8'd0 : pg_r;
  assign prod      = blk_r * ppb_r;
  assign row_sum   = {1'b0, prod} + {18'd0, pg_sel};
  assign row_new   = row_sum[RowAddrBits-1:0];
  assign rowb      = 24'(row_new);
  assign row_cur   = 24'(row_r);
  assign bc_dec    = bc_r - 13'd1;
  assign bc_inc    = bc_r + 13'd1;
  assign polling   = (phase_r == PH_ERASE_POLL) || (phase_r == PH_READ_POLL) ||
                     (phase_r == PH_LOAD_POLL) || (phase_r == PH_EXEC_POLL);
  assign tick_over = TickCmpW'(ticks_r) >= TickCmpW'(to_r);

  always_comb begin
    phase_nxt = phase_r;
    row_nxt   = row_r;
    bc_nxt    = bc_r;
    ticks_nxt = ticks_r;
    piz_nxt   = piz_r;
    mwz_nxt   = mwz_r;
    ls_nxt    = ls_r;
    n         = '0;
    res       = '0;
    if (phase_r == PH_IDLE && op_r == OP_ERASE) begin
      row_nxt   = row_new;
      res[0]    = mk(KIND_FLASH, CMD_WREN, 1'b1, 1'b1, 13'd0, ST_OK);
      res[1]    = mk(KIND_FLASH, CMD_BLOCK_ERASE, 1'b1, 1'b0, 13'd0, ST_OK);
      res[2]    = mk(KIND_FLASH, rowb[23:16], 1'b0, 1'b0, 13'd0, ST_OK);
      res[3]    = mk(KIND_FLASH, rowb[15:8], 1'b0, 1'b0, 13'd0, ST_OK);
      res[4]    = mk(KIND_FLASH, rowb[7:0], 1'b0, 1'b1, 13'd0, ST_OK);
      res[5]    = mk(KIND_FLASH, CMD_FEATURE_RD, 1'b1, 1'b0, 13'd0, ST_OK);
      res[6]    = mk(KIND_FLASH, REG_STATUS_ADDR, 1'b0, 1'b1, 13'd1, ST_OK);
      n         = CntW'(7);
      ticks_nxt = '0;
      phase_nxt = PH_ERASE_POLL;
    end else if (phase_r == PH_IDLE && op_r == OP_READ) begin
      row_nxt   = row_new;
      piz_nxt   = (pg_r == 8'd0);
      res[0]    = mk(KIND_FLASH, CMD_PAGE_READ, 1'b1, 1'b0, 13'd0, ST_OK);
      res[1]    = mk(KIND_FLASH, rowb[23:16], 1'b0, 1'b0, 13'd0, ST_OK);
      res[2]    = mk(KIND_FLASH, rowb[15:8], 1'b0, 1'b0, 13'd0, ST_OK);
      res[3]    = mk(KIND_FLASH, rowb[7:0], 1'b0, 1'b1, 13'd0, ST_OK);
      res[4]    = mk(KIND_FLASH, CMD_FEATURE_RD, 1'b1, 1'b0, 13'd0, ST_OK);
      res[5]    = mk(KIND_FLASH, REG_STATUS_ADDR, 1'b0, 1'b1, 13'd1, ST_OK);
      n         = CntW'(6);
      ticks_nxt = '0;
      phase_nxt = PH_READ_POLL;
    end else if (phase_r == PH_IDLE && op_r == OP_WRITE) begin
      row_nxt = row_new;
      bc_nxt  = {1'b0, len_r};
      res[0]  = mk(KIND_FLASH, CMD_WREN, 1'b1, 1'b1, 13'd0, ST_OK);
      res[1]  = mk(KIND_FLASH, CMD_PROG_LOAD, 1'b1, 1'b0, 13'd0, ST_OK);
      res[2]  = mk(KIND_FLASH, {4'd0, col_r[11:8]}, 1'b0, 1'b0, 13'd0, ST_OK);
      res[3]  = mk(KIND_FLASH, col_r[7:0], 1'b0, (len_r == 12'd0), 13'd0, ST_OK);
      if (len_r == 12'd0) begin
        res[4]    = mk(KIND_FLASH, CMD_FEATURE_RD, 1'b1, 1'b0, 13'd0, ST_OK);
        res[5]    = mk(KIND_FLASH, REG_STATUS_ADDR, 1'b0, 1'b1, 13'd1, ST_OK);
        n         = CntW'(6);
        ticks_nxt = '0;
        phase_nxt = PH_LOAD_POLL;
      end else begin
        n         = CntW'(4);
        phase_nxt = PH_LOAD;
      end
    end else if (op_r == OP_WR_BYTE && phase_r == PH_LOAD) begin
      bc_nxt = bc_dec;
      res[0] = mk(KIND_FLASH, db_r, 1'b0, (bc_dec == 13'd0), 13'd0, ST_OK);
      if (bc_dec == 13'd0) begin
        res[1]    = mk(KIND_FLASH, CMD_FEATURE_RD, 1'b1, 1'b0, 13'd0, ST_OK);
        res[2]    = mk(KIND_FLASH, REG_STATUS_ADDR, 1'b0, 1'b1, 13'd1, ST_OK);
        n         = CntW'(3);
        ticks_nxt = '0;
        phase_nxt = PH_LOAD_POLL;
      end else begin
        n = CntW'(1);
      end
    end else if (op_r == OP_REPLY && phase_r == PH_READ_DATA) begin
      res[0] = mk(KIND_HOST, db_r, 1'b0, 1'b0, 13'd0, ST_OK);
      if (bc_r == {1'b0, pds_r} && db_r == 8'd0) begin
        mwz_nxt = 1'b1;
      end
      bc_nxt = bc_inc;
      if (bc_inc >= ptot_r) begin
        res[1]    = mk(KIND_DONE, 8'd0, 1'b0, 1'b0, 13'd0,
                       (piz_r && mwz_nxt) ? ST_BAD_BLOCK : ST_OK);
        n         = CntW'(2);
        phase_nxt = PH_IDLE;
      end else begin
        n = CntW'(1);
      end
    end else if (op_r == OP_REPLY && polling) begin
      ls_nxt = db_r;
      if (!db_r[BitBusy]) begin
        case (phase_r)
          PH_ERASE_POLL: begin
            res[0]    = mk(KIND_FLASH, CMD_WRITE_DIS, 1'b1, 1'b1, 13'd0, ST_OK);
            res[1]    = mk(KIND_DONE, 8'd0, 1'b0, 1'b0, 13'd0,
                           db_r[BitEraseFail] ? ST_ERASE_FAIL : ST_OK);
            n         = CntW'(2);
            phase_nxt = PH_IDLE;
          end
          PH_READ_POLL: begin
            res[0]  = mk(KIND_FLASH, CMD_CACHE_RD, 1'b1, 1'b0, 13'd0, ST_OK);
            res[1]  = mk(KIND_FLASH, 8'd0, 1'b0, 1'b0, 13'd0, ST_OK);
            res[2]  = mk(KIND_FLASH, 8'd0, 1'b0, 1'b0, 13'd0, ST_OK);
            res[3]  = mk(KIND_FLASH, 8'd0, 1'b0, 1'b1, ptot_r, ST_OK);
            bc_nxt  = '0;
            mwz_nxt = 1'b0;
            if (ptot_r == 13'd0) begin
              res[4]    = mk(KIND_DONE, 8'd0, 1'b0, 1'b0, 13'd0, ST_OK);
              n         = CntW'(5);
              phase_nxt = PH_IDLE;
            end else begin
              n         = CntW'(4);
              phase_nxt = PH_READ_DATA;
            end
          end
          PH_LOAD_POLL: begin
            res[0]    = mk(KIND_FLASH, CMD_PROG_EXEC, 1'b1, 1'b0, 13'd0, ST_OK);
            res[1]    = mk(KIND_FLASH, row_cur[23:16], 1'b0, 1'b0, 13'd0, ST_OK);
            res[2]    = mk(KIND_FLASH, row_cur[15:8], 1'b0, 1'b0, 13'd0, ST_OK);
            res[3]    = mk(KIND_FLASH, row_cur[7:0], 1'b0, 1'b1, 13'd0, ST_OK);
            res[4]    = mk(KIND_FLASH, CMD_FEATURE_RD, 1'b1, 1'b0, 13'd0, ST_OK);
            res[5]    = mk(KIND_FLASH, REG_STATUS_ADDR, 1'b0, 1'b1, 13'd1, ST_OK);
            n         = CntW'(6);
            ticks_nxt = '0;
            phase_nxt = PH_EXEC_POLL;
          end
          default: begin
            res[0]    = mk(KIND_FLASH, CMD_WRITE_DIS, 1'b1, 1'b1, 13'd0, ST_OK);
            res[1]    = mk(KIND_DONE, 8'd0, 1'b0, 1'b0, 13'd0,
                           db_r[BitProgFail] ? ST_PROG_FAIL : ST_OK);
            n         = CntW'(2);
            phase_nxt = PH_IDLE;
          end
        endcase
      end else if (tick_over) begin
        res[0]    = mk(KIND_DONE, 8'd0, 1'b0, 1'b0, 13'd0, ST_TIMEOUT);
        n         = CntW'(1);
        phase_nxt = PH_IDLE;
      end else begin
        res[0] = mk(KIND_FLASH, CMD_FEATURE_RD, 1'b1, 1'b0, 13'd0, ST_OK);
        res[1] = mk(KIND_FLASH, REG_STATUS_ADDR, 1'b0, 1'b1, 13'd1, ST_OK);
        n      = CntW'(2);
      end
    end else if (op_r == OP_TICK && polling) begin
      if (ticks_r != {TickBits{1'b1}}) begin
        ticks_nxt = ticks_r + TickBits'(1);
      end
    end
    for (int i = 0; i < MaxRes; i++) begin
      res[i].last = (CntW'(i + 1) == n);
    end
  end

  assign consume   = vld_r && (load_ok || (n == '0));
  assign accept    = in_tvalid && in_tready;
  assign in_tready = !vld_r || consume;
  assign ld.load   = consume;
  assign ld.n      = n;
  assign list      = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (accept) begin
      vld_r <= 1'b1;
    end else if (consume) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_tuser;
      blk_r <= in_tdata[15:0];
      pg_r  <= in_tdata[23:16];
      col_r <= in_tdata[35:24];
      len_r <= in_tdata[47:36];
      db_r  <= in_tdata[55:48];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppb_r  <= PpbReset;
      ptot_r <= PtotReset;
      pds_r  <= PdsReset;
      to_r   <= ToReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAGES_PER_BLOCK: ppb_r  <= cfg_wdata[8:0];
        CFG_PAGE_TOTAL:      ptot_r <= cfg_wdata[12:0];
        CFG_PAGE_DATA_SIZE:  pds_r  <= cfg_wdata[11:0];
        CFG_TIMEOUT_TICKS:   to_r   <= cfg_wdata;
        default:             to_r   <= to_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      row_r   <= '0;
      bc_r    <= '0;
      ticks_r <= '0;
      piz_r   <= 1'b0;
      mwz_r   <= 1'b0;
      ls_r    <= '0;
    end else if (consume) begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      bc_r    <= bc_nxt;
      ticks_r <= ticks_nxt;
      piz_r   <= piz_nxt;
      mwz_r   <= mwz_nxt;
      ls_r    <= ls_nxt;
    end
  end

endmodule

// ===== sv/sncs_burst.sv =====
module sncs_burst (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  sncs_pkg::load_t                       ld,
  input  sncs_pkg::res_t [sncs_pkg::MaxRes-1:0] list,
  output logic                                  load_ok,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [31:0]                           out_tdata,
  output logic [1:0]                            out_tuser,
  output logic                                  out_tlast
);
  import sncs_pkg::*;

  res_t [MaxRes-1:0] ent_r, ent_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              pop;
  res_t              head;

  assign head       = ent_r[0];
  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign load_ok    = (cnt_r == '0) || ((cnt_r == CntW'(1)) && pop);
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;
  assign out_tdata  = {6'd0, head.status_code, head.reply_count, head.frame_end,
                       head.frame_start, head.data};

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (ld.load && (ld.n != '0)) begin
      ent_nxt = list;
      cnt_nxt = ld.n;
    end else if (pop) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        ent_nxt[i] = ent_r[i + 1];
      end
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ld.load && (ld.n != '0)) |-> load_ok)
    else $error("burst loaded while results still pending");
  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (head.last == (cnt_r == CntW'(1))))
    else $error("last flag does not match final queued result");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxRes))
    else $error("result count exceeds queue depth");
  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !ld.load && (cnt_r > CntW'(1))) |=> (cnt_r == $past(cnt_r) - CntW'(1)))
    else $error("queue count did not step down on pop");
`endif

endmodule

// ===== sv/spi_nand_command_sequencer.sv =====
// SPI NAND command sequencer.
// Host operations, write data bytes, flash reply bytes and timer ticks enter on
// the in_ stream, with the operation code in in_tuser. Each item expands into
// zero to seven result items on the out_ stream: bytes to send to the flash with
// chip select framing, read bytes for the host, or an operation finished item
// that carries the status code. out_tlast marks the last result of one item.
// An accepted item is held in an input register and is processed from there once
// the result queue can take its results, which are registered in that queue.
// Results leave one per cycle, while out_tready is high, from a seven-entry result
// queue, and a new item is processed as the queue hands out its final entry.
// Items that cause no result, such as ticks, pass at one per cycle even while the
// queue drains.
// The row address takes one 16 by 9 bit multiply and an add in the processing cycle.
// When out_tready is low, the queue holds and in_tready drops once the input
// register holds an item whose results the queue cannot take. Configuration
// writes on cfg_ take effect at the next edge. Synchronous reset returns to idle
// with an empty queue and the configuration registers at their default values.
module spi_nand_command_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // block[15:0], page[23:16], column[35:24], length[47:36], data_byte[55:48]
  input  logic [55:0] in_tdata,
  // operation[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_byte[7:0], frame_start[8], frame_end[9], reply_count[22:10],
  // status_code[25:23], zero[31:26]
  output logic [31:0] out_tdata,
  // out_kind[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import sncs_pkg::*;

  load_t             ld;
  res_t [MaxRes-1:0] list;
  logic              load_ok;

  sncs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .load_ok   (load_ok),
    .ld        (ld),
    .list      (list)
  );

  sncs_burst u_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (ld),
    .list       (list),
    .load_ok    (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
